// ===== sv/tts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants of the triangle tangent unit
// Field widths, internal datapath widths, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tts_pkg;

   // transaction field widths
   localparam int PosW = 24;
   localparam int TexW = 16;
   localparam int NrmW = 16;
   localparam int TanW = 16;

   // internal widths
   localparam int EdgeW = PosW + 1;
   localparam int UvdW  = TexW + 1;
   localparam int DetW  = 35;
   localparam int OpW   = 33;
   localparam int ProdW = 2 * OpW;
   localparam int AccW  = ProdW;
   localparam int DotW  = 49;
   localparam int MagW  = 63;
   localparam int DirW  = 31;
   localparam int RootW = 32;
   localparam int QuoW  = 15;
   localparam int DivW  = 47;

   // fixed-point shifts and iteration counts
   localparam int ScaleLoBit   = 29;
   localparam int FracShift    = 28;
   localparam int DotSplit     = 24;
   localparam int TanShift     = 15;
   localparam int SqrtStartBit = 60;
   localparam int SqrtSteps    = 31;
   localparam int DivSteps     = QuoW;
   localparam int NumAxes      = 3;
   localparam int NumCorners   = 3;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_S1T2,
      MUL_S2T1,
      MUL_T2E1,
      MUL_T1E2,
      MUL_NT,
      MUL_NDH,
      MUL_NDL,
      MUL_SQ
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB,
      ACC_SUB_HI,
      ACC_LOAD_T
   } acc_op_type;

   typedef enum logic [3:0] {
      ST_NONE,
      ST_DIFF,
      ST_DET,
      ST_VEC,
      ST_TCOPY,
      ST_DOT,
      ST_SQRT_INIT,
      ST_DIV_INIT,
      ST_TANG
   } st_op_type;

   typedef struct packed {
      logic        cap_en;
      logic [1:0]  cap_slot;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      st_op_type   st_op;
      logic [1:0]  axis;
      logic [1:0]  corner;
      logic        flip;
      logic        scale_step;
      logic        sqrt_step;
      logic        div_step;
      logic        out_load;
      logic        out_degen;
   } cmd_type;

   typedef struct packed {
      logic scale_done;
      logic vec_zero;
      logic det_zero;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ===== sv/tts_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tts_req_if: vertex channel
// One vertex per transaction: position, texture coordinate and normal.
// ----------------------------------------------------------------------------
interface tts_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [tts_pkg::PosW-1:0]   position_x;
   logic signed [tts_pkg::PosW-1:0]   position_y;
   logic signed [tts_pkg::PosW-1:0]   position_z;
   logic signed [tts_pkg::TexW-1:0]   tex_u;
   logic signed [tts_pkg::TexW-1:0]   tex_v;
   logic signed [tts_pkg::NrmW-1:0]   normal_x;
   logic signed [tts_pkg::NrmW-1:0]   normal_y;
   logic signed [tts_pkg::NrmW-1:0]   normal_z;

   modport source (
      output valid, position_x, position_y, position_z, tex_u, tex_v,
             normal_x, normal_y, normal_z,
      input  ready
   );
   modport sink (
      input  valid, position_x, position_y, position_z, tex_u, tex_v,
             normal_x, normal_y, normal_z,
      output ready
   );
endinterface
`default_nettype wire

// ===== sv/tts_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tts_rsp_if: tangent channel
// One corner tangent per transaction with its flags.
// ----------------------------------------------------------------------------
interface tts_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [tts_pkg::TanW-1:0]   tangent_x;
   logic signed [tts_pkg::TanW-1:0]   tangent_y;
   logic signed [tts_pkg::TanW-1:0]   tangent_z;
   logic                              degenerate;
   logic [1:0]                        corner_index;
   logic                              last_of_triangle;

   modport source (
      output valid, tangent_x, tangent_y, tangent_z, degenerate, corner_index,
             last_of_triangle,
      input  ready
   );
   modport sink (
      input  valid, tangent_x, tangent_y, tangent_z, degenerate, corner_index,
             last_of_triangle,
      output ready
   );
endinterface
`default_nettype wire

// ===== sv/tts_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tts_dpath: tangent datapath
// Vertex store, shared 33x33 multiplier with accumulator, block-scaling
// shifter, bit-serial square root, restoring divider and output register.
// ----------------------------------------------------------------------------
module tts_dpath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire tts_pkg::cmd_type                 cmd,
   output tts_pkg::status_type                   status,
   input  wire logic signed [tts_pkg::PosW-1:0]  in_pos_x,
   input  wire logic signed [tts_pkg::PosW-1:0]  in_pos_y,
   input  wire logic signed [tts_pkg::PosW-1:0]  in_pos_z,
   input  wire logic signed [tts_pkg::TexW-1:0]  in_tex_u,
   input  wire logic signed [tts_pkg::TexW-1:0]  in_tex_v,
   input  wire logic signed [tts_pkg::NrmW-1:0]  in_nrm_x,
   input  wire logic signed [tts_pkg::NrmW-1:0]  in_nrm_y,
   input  wire logic signed [tts_pkg::NrmW-1:0]  in_nrm_z,
   output logic                                  out_valid,
   input  wire logic                             out_ready,
   output logic signed [tts_pkg::TanW-1:0]       out_tan_x,
   output logic signed [tts_pkg::TanW-1:0]       out_tan_y,
   output logic signed [tts_pkg::TanW-1:0]       out_tan_z,
   output logic                                  out_degen,
   output logic [1:0]                            out_corner,
   output logic                                  out_last
);
   localparam int OW   = tts_pkg::OpW;
   localparam int AW   = tts_pkg::AccW;
   localparam int MW   = tts_pkg::MagW;
   localparam int EW   = tts_pkg::EdgeW;
   localparam int UW   = tts_pkg::UvdW;
   localparam int DW   = tts_pkg::DirW;
   localparam int QW   = tts_pkg::QuoW;
   localparam int VW   = tts_pkg::DivW;
   localparam int RW   = tts_pkg::RootW;
   localparam int LoB  = tts_pkg::ScaleLoBit;
   localparam int Spl  = tts_pkg::DotSplit;
   localparam int NA   = tts_pkg::NumAxes;

   logic signed [tts_pkg::PosW-1:0] pos_ff [tts_pkg::NumCorners][NA];
   logic signed [tts_pkg::TexW-1:0] tex_ff [tts_pkg::NumCorners][2];
   logic signed [tts_pkg::NrmW-1:0] nrm_ff [tts_pkg::NumCorners][NA];

   logic signed [EW-1:0]             edge1_ff [NA];
   logic signed [EW-1:0]             edge2_ff [NA];
   logic signed [UW-1:0]             s1_ff, t1_ff, s2_ff, t2_ff;
   logic signed [OW-1:0]             op_a, op_b;
   logic signed [tts_pkg::ProdW-1:0] prod_ff;
   logic signed [AW-1:0]             acc_ff, acc_in, acc_abs, dir_ext;
   logic signed [tts_pkg::DetW-1:0]  det_ff;
   logic signed [tts_pkg::DotW-1:0]  dot_ff;
   logic [MW-1:0]                    mag_ff [NA];
   logic                             neg_ff [NA];
   logic [MW-1:0]                    mag_or;
   logic signed [DW-1:0]             dir_ff [NA];
   logic [MW-1:0]                    rem_ff, root_ff, bit_ff;
   logic [MW:0]                      sq_sum;
   logic [VW-1:0]                    drem_ff, dsh_ff;
   logic [QW-1:0]                    quo_ff;
   logic signed [tts_pkg::TanW-1:0]  tan_ff [NA];
   logic signed [tts_pkg::TanW-1:0]  quo_s;
   logic signed [DW-1:0]             dmag [NA];
   logic                             scale_hi;

   // vertex capture
   always_ff @(posedge clock) begin
      if (cmd.cap_en) begin
         pos_ff[cmd.cap_slot][0] <= in_pos_x;
         pos_ff[cmd.cap_slot][1] <= in_pos_y;
         pos_ff[cmd.cap_slot][2] <= in_pos_z;
         tex_ff[cmd.cap_slot][0] <= in_tex_u;
         tex_ff[cmd.cap_slot][1] <= in_tex_v;
         nrm_ff[cmd.cap_slot][0] <= in_nrm_x;
         nrm_ff[cmd.cap_slot][1] <= in_nrm_y;
         nrm_ff[cmd.cap_slot][2] <= in_nrm_z;
      end
   end

   // multiplier operand select
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cmd.mul_sel)
         tts_pkg::MUL_S1T2: begin
            op_a = OW'(s1_ff);
            op_b = OW'(t2_ff);
         end
         tts_pkg::MUL_S2T1: begin
            op_a = OW'(s2_ff);
            op_b = OW'(t1_ff);
         end
         tts_pkg::MUL_T2E1: begin
            op_a = OW'(t2_ff);
            op_b = OW'(edge1_ff[cmd.axis]);
         end
         tts_pkg::MUL_T1E2: begin
            op_a = OW'(t1_ff);
            op_b = OW'(edge2_ff[cmd.axis]);
         end
         tts_pkg::MUL_NT: begin
            op_a = OW'(nrm_ff[cmd.corner][cmd.axis]);
            op_b = OW'(dir_ff[cmd.axis]);
         end
         tts_pkg::MUL_NDH: begin
            op_a = OW'(nrm_ff[cmd.corner][cmd.axis]);
            op_b = OW'($signed(dot_ff[tts_pkg::DotW-1:Spl]));
         end
         tts_pkg::MUL_NDL: begin
            op_a = OW'(nrm_ff[cmd.corner][cmd.axis]);
            op_b = $signed({{(OW-Spl){1'b0}}, dot_ff[Spl-1:0]});
         end
         tts_pkg::MUL_SQ: begin
            op_a = $signed({{(OW-LoB-1){1'b0}}, mag_ff[cmd.axis][LoB:0]});
            op_b = $signed({{(OW-LoB-1){1'b0}}, mag_ff[cmd.axis][LoB:0]});
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   // accumulator
   assign dir_ext = AW'(dir_ff[cmd.axis]);

   always_comb begin
      case (cmd.acc_op)
         tts_pkg::ACC_LOAD:   acc_in = prod_ff;
         tts_pkg::ACC_ADD:    acc_in = acc_ff + prod_ff;
         tts_pkg::ACC_SUB:    acc_in = acc_ff - prod_ff;
         tts_pkg::ACC_SUB_HI: acc_in = acc_ff - (prod_ff <<< Spl);
         tts_pkg::ACC_LOAD_T: acc_in = dir_ext <<< tts_pkg::FracShift;
         default:             acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc_abs = acc_ff[AW-1] ? -acc_ff : acc_ff;

   // block scaling: largest magnitude settles in [2^29, 2^30)
   assign mag_or   = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign scale_hi = |mag_or[MW-1:LoB+1];

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         dmag[a] = $signed({1'b0, mag_ff[a][LoB:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.st_op == tts_pkg::ST_DIFF) begin
         for (int a = 0; a < NA; a++) begin
            edge1_ff[a] <= EW'(pos_ff[1][a]) - EW'(pos_ff[0][a]);
            edge2_ff[a] <= EW'(pos_ff[2][a]) - EW'(pos_ff[0][a]);
         end
         s1_ff <= UW'(tex_ff[1][0]) - UW'(tex_ff[0][0]);
         t1_ff <= UW'(tex_ff[1][1]) - UW'(tex_ff[0][1]);
         s2_ff <= UW'(tex_ff[2][0]) - UW'(tex_ff[0][0]);
         t2_ff <= UW'(tex_ff[2][1]) - UW'(tex_ff[0][1]);
      end
      if (cmd.st_op == tts_pkg::ST_DET) begin
         det_ff <= acc_ff[tts_pkg::DetW-1:0];
      end
      if (cmd.st_op == tts_pkg::ST_DOT) begin
         dot_ff <= acc_ff[tts_pkg::DotW-1:0];
      end
      if (cmd.st_op == tts_pkg::ST_TCOPY) begin
         for (int a = 0; a < NA; a++) begin
            dir_ff[a] <= neg_ff[a] ? -dmag[a] : dmag[a];
         end
      end
   end

   // direction vector magnitudes and signs
   always_ff @(posedge clock) begin
      if (cmd.st_op == tts_pkg::ST_VEC) begin
         mag_ff[cmd.axis] <= acc_abs[MW-1:0];
         neg_ff[cmd.axis] <= acc_ff[AW-1] ^ (cmd.flip & det_ff[tts_pkg::DetW-1]);
      end else if (cmd.scale_step) begin
         for (int a = 0; a < NA; a++) begin
            mag_ff[a] <= scale_hi ? (mag_ff[a] >> 1) : (mag_ff[a] << 1);
         end
      end
   end

   // bit-serial square root
   assign sq_sum = {1'b0, root_ff} + {1'b0, bit_ff};

   always_ff @(posedge clock) begin
      if (cmd.st_op == tts_pkg::ST_SQRT_INIT) begin
         rem_ff  <= acc_ff[MW-1:0];
         root_ff <= '0;
         bit_ff  <= MW'(1) << tts_pkg::SqrtStartBit;
      end else if (cmd.sqrt_step) begin
         if ({1'b0, rem_ff} >= sq_sum) begin
            rem_ff  <= rem_ff - sq_sum[MW-1:0];
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // restoring divider: (mag*2^15 + L) / (2L)
   always_ff @(posedge clock) begin
      if (cmd.st_op == tts_pkg::ST_DIV_INIT) begin
         drem_ff <= VW'({mag_ff[cmd.axis][LoB:0], {tts_pkg::TanShift{1'b0}}})
                    + VW'(root_ff[RW-1:0]);
         dsh_ff  <= VW'({root_ff[RW-1:0], {tts_pkg::TanShift{1'b0}}});
         quo_ff  <= '0;
      end else if (cmd.div_step) begin
         if (drem_ff >= dsh_ff) begin
            drem_ff <= drem_ff - dsh_ff;
            quo_ff  <= {quo_ff[QW-2:0], 1'b1};
         end else begin
            quo_ff  <= {quo_ff[QW-2:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
      end
   end

   assign quo_s = $signed({1'b0, quo_ff});

   always_ff @(posedge clock) begin
      if (cmd.st_op == tts_pkg::ST_TANG) begin
         tan_ff[cmd.axis] <= neg_ff[cmd.axis] ? -quo_s : quo_s;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid <= 1'b1;
      end else if (out_ready) begin
         out_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_tan_x  <= cmd.out_degen ? '0 : tan_ff[0];
         out_tan_y  <= cmd.out_degen ? '0 : tan_ff[1];
         out_tan_z  <= cmd.out_degen ? '0 : tan_ff[2];
         out_degen  <= cmd.out_degen;
         out_corner <= cmd.corner;
         out_last   <= (cmd.corner == 2'(tts_pkg::NumCorners - 1));
      end
   end

   assign status.scale_done = !scale_hi && (mag_or[LoB] || (mag_or == '0));
   assign status.vec_zero   = (mag_or == '0);
   assign status.det_zero   = (det_ff == '0);
   assign status.out_free   = !out_valid || out_ready;

endmodule
`default_nettype wire

// ===== sv/tts_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tts_ctrl: tangent sequencer
// Counts corners, and on the third one steps the datapath through the
// determinant, direction, per-corner orthogonalization, root and division.
// ----------------------------------------------------------------------------
module tts_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output tts_pkg::cmd_type         cmd,
   input  wire tts_pkg::status_type status
);
   typedef enum logic [4:0] {
      IDLE, DIFF, DET_M1, DET_M2, DET_A, DET_ST, DET_CHK,
      TD_M1, TD_M2, TD_A, TD_ST, T_SCALE, T_COPY,
      D_M, D_A, D_ST, G_L, G_H, G_LO, G_ST, G_SCALE,
      S_M, S_A, S_ST, SQ, DV_INIT, DV, DV_ST, EMIT
   } state_type;

   localparam logic [1:0] LastAxis   = 2'(tts_pkg::NumAxes - 1);
   localparam logic [1:0] LastCorner = 2'(tts_pkg::NumCorners - 1);
   localparam logic [4:0] SqrtLast   = 5'(tts_pkg::SqrtSteps - 1);
   localparam logic [4:0] DivLast    = 5'(tts_pkg::DivSteps - 1);

   state_type  state_ff;
   logic [1:0] count_ff;
   logic [1:0] ax_ff;
   logic [1:0] cn_ff;
   logic [4:0] it_ff;
   logic       degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         count_ff <= '0;
         ax_ff    <= '0;
         cn_ff    <= '0;
         it_ff    <= '0;
         degen_ff <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  if (count_ff == LastCorner) begin
                     count_ff <= '0;
                     state_ff <= DIFF;
                  end else begin
                     count_ff <= count_ff + 2'd1;
                  end
               end
            end
            DIFF:   state_ff <= DET_M1;
            DET_M1: state_ff <= DET_M2;
            DET_M2: state_ff <= DET_A;
            DET_A:  state_ff <= DET_ST;
            DET_ST: state_ff <= DET_CHK;
            DET_CHK: begin
               cn_ff <= '0;
               ax_ff <= '0;
               if (status.det_zero) begin
                  degen_ff <= 1'b1;
                  state_ff <= EMIT;
               end else begin
                  state_ff <= TD_M1;
               end
            end
            TD_M1: state_ff <= TD_M2;
            TD_M2: state_ff <= TD_A;
            TD_A:  state_ff <= TD_ST;
            TD_ST: begin
               if (ax_ff == LastAxis) begin
                  state_ff <= T_SCALE;
               end else begin
                  ax_ff    <= ax_ff + 2'd1;
                  state_ff <= TD_M1;
               end
            end
            T_SCALE: begin
               if (status.scale_done) begin
                  state_ff <= T_COPY;
               end
            end
            T_COPY: begin
               ax_ff    <= '0;
               state_ff <= D_M;
            end
            D_M: state_ff <= D_A;
            D_A: begin
               if (ax_ff == LastAxis) begin
                  ax_ff    <= '0;
                  state_ff <= D_ST;
               end else begin
                  ax_ff    <= ax_ff + 2'd1;
                  state_ff <= D_M;
               end
            end
            D_ST: state_ff <= G_L;
            G_L:  state_ff <= G_H;
            G_H:  state_ff <= G_LO;
            G_LO: state_ff <= G_ST;
            G_ST: begin
               if (ax_ff == LastAxis) begin
                  state_ff <= G_SCALE;
               end else begin
                  ax_ff    <= ax_ff + 2'd1;
                  state_ff <= G_L;
               end
            end
            G_SCALE: begin
               if (status.scale_done) begin
                  ax_ff <= '0;
                  if (status.vec_zero) begin
                     degen_ff <= 1'b1;
                     state_ff <= EMIT;
                  end else begin
                     degen_ff <= 1'b0;
                     state_ff <= S_M;
                  end
               end
            end
            S_M: state_ff <= S_A;
            S_A: begin
               if (ax_ff == LastAxis) begin
                  ax_ff    <= '0;
                  state_ff <= S_ST;
               end else begin
                  ax_ff    <= ax_ff + 2'd1;
                  state_ff <= S_M;
               end
            end
            S_ST: begin
               it_ff    <= '0;
               state_ff <= SQ;
            end
            SQ: begin
               if (it_ff == SqrtLast) begin
                  ax_ff    <= '0;
                  state_ff <= DV_INIT;
               end else begin
                  it_ff <= it_ff + 5'd1;
               end
            end
            DV_INIT: begin
               it_ff    <= '0;
               state_ff <= DV;
            end
            DV: begin
               if (it_ff == DivLast) begin
                  state_ff <= DV_ST;
               end else begin
                  it_ff <= it_ff + 5'd1;
               end
            end
            DV_ST: begin
               if (ax_ff == LastAxis) begin
                  state_ff <= EMIT;
               end else begin
                  ax_ff    <= ax_ff + 2'd1;
                  state_ff <= DV_INIT;
               end
            end
            EMIT: begin
               if (status.out_free) begin
                  ax_ff <= '0;
                  if (cn_ff == LastCorner) begin
                     cn_ff    <= '0;
                     state_ff <= IDLE;
                  end else begin
                     cn_ff <= cn_ff + 2'd1;
                     // zero determinant: every corner goes straight out
                     if (!status.det_zero) begin
                        state_ff <= D_M;
                     end
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = tts_pkg::MUL_NONE;
      cmd.acc_op   = tts_pkg::ACC_NONE;
      cmd.st_op    = tts_pkg::ST_NONE;
      cmd.axis     = ax_ff;
      cmd.corner   = cn_ff;
      cmd.cap_slot = count_ff;
      req_ready    = 1'b0;
      case (state_ff)
         IDLE: begin
            req_ready  = 1'b1;
            cmd.cap_en = req_valid;
         end
         DIFF:   cmd.st_op = tts_pkg::ST_DIFF;
         DET_M1: cmd.mul_sel = tts_pkg::MUL_S1T2;
         DET_M2: begin
            cmd.mul_sel = tts_pkg::MUL_S2T1;
            cmd.acc_op  = tts_pkg::ACC_LOAD;
         end
         DET_A:  cmd.acc_op = tts_pkg::ACC_SUB;
         DET_ST: cmd.st_op = tts_pkg::ST_DET;
         TD_M1:  cmd.mul_sel = tts_pkg::MUL_T2E1;
         TD_M2: begin
            cmd.mul_sel = tts_pkg::MUL_T1E2;
            cmd.acc_op  = tts_pkg::ACC_LOAD;
         end
         TD_A:   cmd.acc_op = tts_pkg::ACC_SUB;
         TD_ST: begin
            cmd.st_op = tts_pkg::ST_VEC;
            cmd.flip  = 1'b1;
         end
         T_SCALE: cmd.scale_step = !status.scale_done;
         T_COPY:  cmd.st_op = tts_pkg::ST_TCOPY;
         D_M:     cmd.mul_sel = tts_pkg::MUL_NT;
         D_A:     cmd.acc_op = (ax_ff == '0) ? tts_pkg::ACC_LOAD : tts_pkg::ACC_ADD;
         D_ST:    cmd.st_op = tts_pkg::ST_DOT;
         G_L: begin
            cmd.mul_sel = tts_pkg::MUL_NDH;
            cmd.acc_op  = tts_pkg::ACC_LOAD_T;
         end
         G_H: begin
            cmd.mul_sel = tts_pkg::MUL_NDL;
            cmd.acc_op  = tts_pkg::ACC_SUB_HI;
         end
         G_LO:    cmd.acc_op = tts_pkg::ACC_SUB;
         G_ST:    cmd.st_op = tts_pkg::ST_VEC;
         G_SCALE: cmd.scale_step = !status.scale_done;
         S_M:     cmd.mul_sel = tts_pkg::MUL_SQ;
         S_A:     cmd.acc_op = (ax_ff == '0) ? tts_pkg::ACC_LOAD : tts_pkg::ACC_ADD;
         S_ST:    cmd.st_op = tts_pkg::ST_SQRT_INIT;
         SQ:      cmd.sqrt_step = 1'b1;
         DV_INIT: cmd.st_op = tts_pkg::ST_DIV_INIT;
         DV:      cmd.div_step = 1'b1;
         DV_ST:   cmd.st_op = tts_pkg::ST_TANG;
         EMIT: begin
            cmd.out_load  = status.out_free;
            cmd.out_degen = degen_ff;
         end
         default: cmd.st_op = tts_pkg::ST_NONE;
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/triangle_tangent_gram_schmidt.sv =====
`default_nettype none
// First and second vertex of a triangle: captured, no result.
// Third vertex: the first tangent follows the determinant and, if nonzero, the
// direction and that corner's vector, each with its block-scaling shifts; each
// further corner repeats the per-corner part (31-step root, three 15-step
// divisions). One triangle is in work at a time; the next vertex waits until
// the third tangent is in the output register. Reset clears the corner count.
// ----------------------------------------------------------------------------
// triangle_tangent_gram_schmidt: per-triangle tangent unit
// Forms the triangle's s-direction, orthogonalizes it against each corner
// normal and normalizes it to a Q1.14 tangent.
// ----------------------------------------------------------------------------
module triangle_tangent_gram_schmidt (
   input  wire logic clock,
   input  wire logic reset,
   tts_req_if.sink   req_chan,
   tts_rsp_if.source rsp_chan
);
   tts_pkg::cmd_type    cmd;
   tts_pkg::status_type status;
   logic                req_ready;

   assign req_chan.ready = req_ready;

   tts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   tts_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_pos_x   (req_chan.position_x),
      .in_pos_y   (req_chan.position_y),
      .in_pos_z   (req_chan.position_z),
      .in_tex_u   (req_chan.tex_u),
      .in_tex_v   (req_chan.tex_v),
      .in_nrm_x   (req_chan.normal_x),
      .in_nrm_y   (req_chan.normal_y),
      .in_nrm_z   (req_chan.normal_z),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_tan_x  (rsp_chan.tangent_x),
      .out_tan_y  (rsp_chan.tangent_y),
      .out_tan_z  (rsp_chan.tangent_z),
      .out_degen  (rsp_chan.degenerate),
      .out_corner (rsp_chan.corner_index),
      .out_last   (rsp_chan.last_of_triangle)
   );

endmodule
`default_nettype wire

// ===== tb/sv/triangle_tangent_gram_schmidt_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_tangent_gram_schmidt_tb: self-checking bench of the tangent unit
// Feeds vertex triangles (a directed table, then random triangles), predicts
// the three corner tangents of every triangle and checks each tangent
// transaction in order, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module triangle_tangent_gram_schmidt_tb;

   typedef struct {
      logic signed [tts_pkg::PosW-1:0] px, py, pz;
      logic signed [tts_pkg::TexW-1:0] tu, tv;
      logic signed [tts_pkg::NrmW-1:0] nx, ny, nz;
   } vertex_type;

   typedef struct {
      logic signed [tts_pkg::TanW-1:0] tx, ty, tz;
      logic                            degen;
      logic [1:0]                      corner;
      logic                            last;
   } tangent_type;

   typedef enum {ROW_PREDICT, ROW_ZERO_DET, ROW_UNIT_X} row_kind_type;

   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles   = 600;

   logic clock = 0;
   logic reset = 1;
   tts_req_if req_chan ();
   tts_rsp_if rsp_chan ();

   triangle_tangent_gram_schmidt DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   tangent_type  tangent_q[$];
   vertex_type   row_vtx[$];
   row_kind_type row_kind[$];
   int           error_count = 0;
   int           idle_cycles = 0;
   logic         rsp_calm = 0;

   // predictor state
   int           held_count = 0;
   vertex_type   held_vtx[2];

   initial forever #5 clock = ~clock;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // magnitude scaling by powers of two into [2^29, 2^30), truncating
   function automatic void scale_vec(inout longint v[3]);
      longint unsigned mag[3];
      longint unsigned m;
      m = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = (v[i] < 0) ? -v[i] : v[i];
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) return;
      while (m >= (64'd1 << 30)) begin
         m >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (m < (64'd1 << 29)) begin
         m <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) v[i] = (v[i] < 0) ? -longint'(mag[i]) : longint'(mag[i]);
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // returns 1 and fills tri_out when the vertex closes a triangle
   function automatic bit predict_tangents(input vertex_type v, output tangent_type tri_out[3]);
      vertex_type c[3];
      longint  e1[3], e2[3], dir[3], g[3], nrm[3];
      longint  s1, t1, s2, t2, det, dot;
      longint unsigned mag[3], sq, root, q;
      if (held_count < 2) begin
         held_vtx[held_count] = v;
         held_count++;
         return 0;
      end
      held_count = 0;
      c[0] = held_vtx[0];
      c[1] = held_vtx[1];
      c[2] = v;
      e1[0] = longint'(c[1].px) - c[0].px;
      e1[1] = longint'(c[1].py) - c[0].py;
      e1[2] = longint'(c[1].pz) - c[0].pz;
      e2[0] = longint'(c[2].px) - c[0].px;
      e2[1] = longint'(c[2].py) - c[0].py;
      e2[2] = longint'(c[2].pz) - c[0].pz;
      s1 = longint'(c[1].tu) - c[0].tu;
      t1 = longint'(c[1].tv) - c[0].tv;
      s2 = longint'(c[2].tu) - c[0].tu;
      t2 = longint'(c[2].tv) - c[0].tv;
      det = s1 * t2 - s2 * t1;
      for (int a = 0; a < 3; a++) begin
         dir[a] = t2 * e1[a] - t1 * e2[a];
         if (det < 0) dir[a] = -dir[a];
      end
      scale_vec(dir);
      for (int k = 0; k < 3; k++) begin
         tri_out[k] = '{tx: 0, ty: 0, tz: 0, degen: 1, corner: k[1:0], last: (k == 2)};
         if (det != 0) begin
            nrm[0] = c[k].nx;
            nrm[1] = c[k].ny;
            nrm[2] = c[k].nz;
            dot = nrm[0] * dir[0] + nrm[1] * dir[1] + nrm[2] * dir[2];
            for (int a = 0; a < 3; a++) g[a] = dir[a] * (64'sd1 <<< 28) - nrm[a] * dot;
            scale_vec(g);
            if (g[0] != 0 || g[1] != 0 || g[2] != 0) begin
               sq = 0;
               for (int a = 0; a < 3; a++) begin
                  mag[a] = (g[a] < 0) ? -g[a] : g[a];
                  sq += mag[a] * mag[a];
               end
               root = int_sqrt(sq);
               for (int a = 0; a < 3; a++) begin
                  q = (mag[a] * 32768 + root) / (2 * root);
                  mag[a] = q;
               end
               tri_out[k].tx = (g[0] < 0) ? -longint'(mag[0]) : longint'(mag[0]);
               tri_out[k].ty = (g[1] < 0) ? -longint'(mag[1]) : longint'(mag[1]);
               tri_out[k].tz = (g[2] < 0) ? -longint'(mag[2]) : longint'(mag[2]);
               tri_out[k].degen = 0;
            end
         end
      end
      return 1;
   endfunction

   task automatic send_vertex(input vertex_type v, input row_kind_type kind, input bit calm);
      tangent_type tri_out[3];
      @(negedge clock);
      if (!calm && $urandom_range(99) < 30) begin
         req_chan.valid <= 0;
         do @(negedge clock); while ($urandom_range(99) < 30);
      end
      req_chan.valid      <= 1;
      req_chan.position_x <= v.px;
      req_chan.position_y <= v.py;
      req_chan.position_z <= v.pz;
      req_chan.tex_u      <= v.tu;
      req_chan.tex_v      <= v.tv;
      req_chan.normal_x   <= v.nx;
      req_chan.normal_y   <= v.ny;
      req_chan.normal_z   <= v.nz;
      do @(posedge clock); while (!req_chan.ready);
      if (predict_tangents(v, tri_out)) begin
         for (int k = 0; k < 3; k++) begin
            if (kind == ROW_ZERO_DET)
               tri_out[k] = '{tx: 0, ty: 0, tz: 0, degen: 1, corner: k[1:0], last: (k == 2)};
            else if (kind == ROW_UNIT_X)
               tri_out[k] = '{tx: 16384, ty: 0, tz: 0, degen: 0, corner: k[1:0],
                              last: (k == 2)};
            tangent_q.insert(tangent_q.size(), tri_out[k]);
         end
      end
   endtask

   task automatic add_row(input int px, py, pz, tu, tv, nx, ny, nz, input row_kind_type kind);
      vertex_type v;
      v = '{px: px, py: py, pz: pz, tu: tu, tv: tv, nx: nx, ny: ny, nz: nz};
      row_vtx.insert(row_vtx.size(), v);
      row_kind.insert(row_kind.size(), kind);
   endtask

   function automatic vertex_type random_vertex(input bit full);
      vertex_type v;
      v.px = full ? $urandom : $urandom_range(8192) - 4096;
      v.py = full ? $urandom : $urandom_range(8192) - 4096;
      v.pz = full ? $urandom : $urandom_range(8192) - 4096;
      v.tu = full ? $urandom : $urandom_range(8) - 4;
      v.tv = full ? $urandom : $urandom_range(8) - 4;
      if ($urandom_range(9) == 0) begin
         v.nx = $urandom;
         v.ny = $urandom;
         v.nz = $urandom;
      end else begin
         v.nx = $urandom_range(32768) - 16384;
         v.ny = $urandom_range(32768) - 16384;
         v.nz = $urandom_range(32768) - 16384;
      end
      return v;
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 0;
      while (tangent_q.size() != 0) @(negedge clock);
   endtask

   // tangent checker
   always @(posedge clock) begin
      tangent_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (tangent_q.size() == 0) begin
            report_mismatch("extra tangent transaction", 1, 0);
         end else begin
            want = tangent_q.pop_front();
            if (rsp_chan.tangent_x !== want.tx)
               report_mismatch("tangent_x", rsp_chan.tangent_x, want.tx);
            if (rsp_chan.tangent_y !== want.ty)
               report_mismatch("tangent_y", rsp_chan.tangent_y, want.ty);
            if (rsp_chan.tangent_z !== want.tz)
               report_mismatch("tangent_z", rsp_chan.tangent_z, want.tz);
            if (rsp_chan.degenerate !== want.degen)
               report_mismatch("degenerate", rsp_chan.degenerate, want.degen);
            if (rsp_chan.corner_index !== want.corner)
               report_mismatch("corner_index", rsp_chan.corner_index, want.corner);
            if (rsp_chan.last_of_triangle !== want.last)
               report_mismatch("last_of_triangle", rsp_chan.last_of_triangle, want.last);
         end
      end
   end

   // receiver stalls, none while calm
   always @(negedge clock)
      rsp_chan.ready <= rsp_calm || ($urandom_range(99) >= 30);

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("triangle_tangent_gram_schmidt_tb: errors");
         $finish;
      end
   end

   initial begin
      vertex_type v;
      req_chan.valid      = 0;
      req_chan.position_x = 0;
      req_chan.position_y = 0;
      req_chan.position_z = 0;
      req_chan.tex_u      = 0;
      req_chan.tex_v      = 0;
      req_chan.normal_x   = 0;
      req_chan.normal_y   = 0;
      req_chan.normal_z   = 0;
      rsp_chan.ready      = 0;

      // axis-aligned triangle: tangent along +x at every corner
      add_row(0, 0, 0, 0, 0, 0, 0, 16384, ROW_PREDICT);
      add_row(4096, 0, 0, 4096, 0, 0, 0, 16384, ROW_PREDICT);
      add_row(0, 4096, 0, 0, 4096, 0, 0, 16384, ROW_UNIT_X);
      // all texture coordinates equal: zero determinant
      add_row(100, 200, 300, 77, -5, 16384, 0, 0, ROW_PREDICT);
      add_row(-900, 40, 3, 77, -5, 0, 16384, 0, ROW_PREDICT);
      add_row(5, -6000, 12, 77, -5, 0, 0, -16384, ROW_ZERO_DET);
      // direction parallel to the normal at corner 0 and 2
      add_row(0, 0, 0, 0, 0, 16384, 0, 0, ROW_PREDICT);
      add_row(4096, 0, 0, 4096, 0, 0, 16384, 0, ROW_PREDICT);
      add_row(0, 4096, 0, 0, 4096, -16384, 0, 0, ROW_PREDICT);
      // collinear edges
      add_row(0, 0, 0, 0, 0, 0, 0, 16384, ROW_PREDICT);
      add_row(1000, 1000, 1000, 4096, 0, 0, 0, 16384, ROW_PREDICT);
      add_row(2000, 2000, 2000, 0, 4096, 0, 16384, 0, ROW_PREDICT);
      // field extremes, normals out of range
      add_row(-8388608, 8388607, -8388608, -32768, 32767, -32768, 32767, -32768,
              ROW_PREDICT);
      add_row(8388607, -8388608, 8388607, 32767, -32768, 32767, -32768, 32767,
              ROW_PREDICT);
      add_row(-8388608, -8388608, 8388607, 32767, 32767, 16384, -16384, 0, ROW_PREDICT);
      // negative determinant
      add_row(0, 0, 0, 0, 0, 0, 16384, 0, ROW_PREDICT);
      add_row(0, 0, 4096, 0, 4096, 0, 16384, 0, ROW_PREDICT);
      add_row(4096, 0, 0, 4096, 0, 0, 16384, 0, ROW_PREDICT);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      for (int i = 0; i < row_vtx.size(); i++) send_vertex(row_vtx[i], row_kind[i], 0);
      wait_drained();

      for (int i = 0; i < 141; i++) begin
         if (i % 51 == 0) wait_drained();
         rsp_calm = (i >= 60 && i < 90);
         v = random_vertex($urandom_range(3) != 0);
         send_vertex(v, ROW_PREDICT, (i >= 60 && i < 90));
      end
      rsp_calm = 0;

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0 && tangent_q.size() == 0)
         $display("triangle_tangent_gram_schmidt_tb: clean");
      else
         $display("triangle_tangent_gram_schmidt_tb: errors");
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/tts_pkg.sv
sv/tts_req_if.sv
sv/tts_rsp_if.sv
sv/tts_dpath.sv
sv/tts_ctrl.sv
sv/triangle_tangent_gram_schmidt.sv
tb/sv/triangle_tangent_gram_schmidt_tb.sv
